>>> rtl/arb_pkg.sv
// ----------------------------------------------------------------------------
// arb_pkg: shared types and helpers for the affine rectangle bounds block
// Beat formats, register indexes, reset values and saturation helpers.
// ----------------------------------------------------------------------------
package arb_pkg;

  // Fixed-point format of every coordinate and coefficient.
  localparam int FracBits = 16;
  localparam int CoordW   = 32;
  localparam int LenW     = CoordW - 1;
  localparam int ProdW    = 2 * CoordW;
  localparam int FloorW   = ProdW - FracBits;
  localparam int SumW     = FloorW + 2;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic        [LenW-1:0]   len_t;

  typedef struct packed {
    logic signed [CoordW-1:0] rect_x;
    logic signed [CoordW-1:0] rect_y;
    logic        [LenW-1:0]   rect_w;
    logic        [LenW-1:0]   rect_h;
  } rect_t;

  typedef struct packed {
    logic signed [CoordW-1:0] box_left;
    logic signed [CoordW-1:0] box_top;
    logic        [LenW-1:0]   box_width;
    logic        [LenW-1:0]   box_height;
  } box_t;

  // Configuration register indexes.
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegCoefA   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoefB   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCoefC   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoefD   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOffsetX = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOffsetY = 3'd5;

  localparam coord_t CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordW-1){1'b0}}};
  localparam coord_t CoefOne  = CoordW'(64'd1 << FracBits);
  localparam len_t   LenMax   = '1;

  // Saturate a signed SumW-bit value to the coordinate range.
  function automatic coord_t sat_sum(input logic signed [SumW-1:0] v);
    coord_t r;
    if ((v[SumW-1:CoordW-1] == '0) || (v[SumW-1:CoordW-1] == '1)) begin
      r = v[CoordW-1:0];
    end else if (v[SumW-1]) begin
      r = CoordMin;
    end else begin
      r = CoordMax;
    end
    return r;
  endfunction

  // Saturate a signed (CoordW+1)-bit value to the coordinate range.
  function automatic coord_t sat_edge(input logic [CoordW:0] v);
    coord_t r;
    if (v[CoordW] == v[CoordW-1]) begin
      r = v[CoordW-1:0];
    end else if (v[CoordW]) begin
      r = CoordMin;
    end else begin
      r = CoordMax;
    end
    return r;
  endfunction

  function automatic coord_t cmin(input coord_t p, input coord_t q);
    return (p < q) ? p : q;
  endfunction

  function automatic coord_t cmax(input coord_t p, input coord_t q);
    return (p > q) ? p : q;
  endfunction

  // Distance hi - lo with hi >= lo, clipped to the length range.
  function automatic len_t span(input coord_t hi, input coord_t lo);
    logic [CoordW:0] d;
    len_t r;
    d = {hi[CoordW-1], hi} - {lo[CoordW-1], lo};
    if (d[CoordW] || d[CoordW-1]) begin
      r = LenMax;
    end else begin
      r = d[LenW-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/affine_rect_bounds.sv
// ----------------------------------------------------------------------------
// affine_rect_bounds: bounding box of an affine-mapped rectangle
// Maps the four corners of each rectangle through a 2x3 Q16.16 matrix and
// returns the enclosing axis-aligned box as left, top, width and height.
// ----------------------------------------------------------------------------
// Each accepted input beat passes through stages 1 to 5 in order to its output beat.
// Throughput: one beat per cycle; a beat enters in every cycle in which the
// output side takes a beat or the five-stage pipeline still has a free slot.
// The eight 32x32 corner products are the widest step and get a stage alone.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the identity
// matrix with zero offsets.
module affine_rect_bounds
  import arb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoordW-1:0]  cfg_data_i,
  // Rectangle input channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rect_t              in_data_i,
  // Bounding box output channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output box_t               out_data_o
);

  // --------------------------------------------------------------------------
  // Configuration registers. A write to an index past the list is dropped.
  // --------------------------------------------------------------------------
  coord_t coef_a_q, coef_b_q, coef_c_q, coef_d_q, off_x_q, off_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q <= CoefOne;
      coef_b_q <= '0;
      coef_c_q <= '0;
      coef_d_q <= CoefOne;
      off_x_q  <= '0;
      off_y_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCoefA:   coef_a_q <= cfg_data_i;
        RegCoefB:   coef_b_q <= cfg_data_i;
        RegCoefC:   coef_c_q <= cfg_data_i;
        RegCoefD:   coef_d_q <= cfg_data_i;
        RegOffsetX: off_x_q  <= cfg_data_i;
        RegOffsetY: off_y_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. Each stage holds one beat and moves on when the
  // stage after it is empty or moving too; the output register is stage 5.
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  logic s1_en, s2_en, s3_en, s4_en, s5_en;

  assign s5_en = !s5_valid_q || !out_stall_i;
  assign s4_en = !s4_valid_q || s5_en;
  assign s3_en = !s3_valid_q || s4_en;
  assign s2_en = !s2_valid_q || s3_en;
  assign s1_en = !s1_valid_q || s2_en;

  assign in_stall_o  = !s1_en;
  assign out_valid_o = s5_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= in_valid_i;
      if (s2_en) s2_valid_q <= s1_valid_q;
      if (s3_en) s3_valid_q <= s2_valid_q;
      if (s4_en) s4_valid_q <= s3_valid_q;
      if (s5_en) s5_valid_q <= s4_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: register the rectangle edges. The far edges are the origin plus
  // the size, clipped to the coordinate range before they are mapped.
  // --------------------------------------------------------------------------
  coord_t s1_x0_q, s1_y0_q, s1_x1_q, s1_y1_q;
  coord_t s1_x1_d, s1_y1_d;

  assign s1_x1_d = sat_edge({in_data_i.rect_x[CoordW-1], in_data_i.rect_x}
                            + {2'b00, in_data_i.rect_w});
  assign s1_y1_d = sat_edge({in_data_i.rect_y[CoordW-1], in_data_i.rect_y}
                            + {2'b00, in_data_i.rect_h});

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_x0_q <= in_data_i.rect_x;
      s1_y0_q <= in_data_i.rect_y;
      s1_x1_q <= s1_x1_d;
      s1_y1_q <= s1_y1_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: the eight distinct products. Corners share their edges, so each
  // edge meets each of its two coefficients once. Products are full width.
  // --------------------------------------------------------------------------
  logic signed [ProdW-1:0] s2_x0a_q, s2_x1a_q, s2_y0c_q, s2_y1c_q;
  logic signed [ProdW-1:0] s2_x0b_q, s2_x1b_q, s2_y0d_q, s2_y1d_q;

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      s2_x0a_q <= ProdW'(s1_x0_q) * ProdW'(coef_a_q);
      s2_x1a_q <= ProdW'(s1_x1_q) * ProdW'(coef_a_q);
      s2_y0c_q <= ProdW'(s1_y0_q) * ProdW'(coef_c_q);
      s2_y1c_q <= ProdW'(s1_y1_q) * ProdW'(coef_c_q);
      s2_x0b_q <= ProdW'(s1_x0_q) * ProdW'(coef_b_q);
      s2_x1b_q <= ProdW'(s1_x1_q) * ProdW'(coef_b_q);
      s2_y0d_q <= ProdW'(s1_y0_q) * ProdW'(coef_d_q);
      s2_y1d_q <= ProdW'(s1_y1_q) * ProdW'(coef_d_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: mapped corners. Dropping the low fraction bits of a two's
  // complement product floors it. The two floored products and the offset
  // are summed exactly and clipped. Corner 0 is (x0,y0), bit 0 of the corner
  // number picks x1 and bit 1 picks y1.
  // --------------------------------------------------------------------------
  logic signed [FloorW-1:0] fl_xa [2];
  logic signed [FloorW-1:0] fl_yc [2];
  logic signed [FloorW-1:0] fl_xb [2];
  logic signed [FloorW-1:0] fl_yd [2];
  coord_t s3_mx_d [4];
  coord_t s3_my_d [4];
  coord_t s3_mx_q [4];
  coord_t s3_my_q [4];

  assign fl_xa[0] = s2_x0a_q[ProdW-1:FracBits];
  assign fl_xa[1] = s2_x1a_q[ProdW-1:FracBits];
  assign fl_yc[0] = s2_y0c_q[ProdW-1:FracBits];
  assign fl_yc[1] = s2_y1c_q[ProdW-1:FracBits];
  assign fl_xb[0] = s2_x0b_q[ProdW-1:FracBits];
  assign fl_xb[1] = s2_x1b_q[ProdW-1:FracBits];
  assign fl_yd[0] = s2_y0d_q[ProdW-1:FracBits];
  assign fl_yd[1] = s2_y1d_q[ProdW-1:FracBits];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s3_mx_d[i] = sat_sum(SumW'(fl_xa[i % 2]) + SumW'(fl_yc[i / 2]) + SumW'(off_x_q));
      s3_my_d[i] = sat_sum(SumW'(fl_xb[i % 2]) + SumW'(fl_yd[i / 2]) + SumW'(off_y_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_en) begin
      s3_mx_q <= s3_mx_d;
      s3_my_q <= s3_my_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: least and greatest mapped coordinate on each axis, two levels of
  // compares each.
  // --------------------------------------------------------------------------
  coord_t s4_lo_x_q, s4_hi_x_q, s4_lo_y_q, s4_hi_y_q;

  always_ff @(posedge clk_i) begin
    if (s4_en) begin
      s4_lo_x_q <= cmin(cmin(s3_mx_q[0], s3_mx_q[1]), cmin(s3_mx_q[2], s3_mx_q[3]));
      s4_hi_x_q <= cmax(cmax(s3_mx_q[0], s3_mx_q[1]), cmax(s3_mx_q[2], s3_mx_q[3]));
      s4_lo_y_q <= cmin(cmin(s3_my_q[0], s3_my_q[1]), cmin(s3_my_q[2], s3_my_q[3]));
      s4_hi_y_q <= cmax(cmax(s3_my_q[0], s3_my_q[1]), cmax(s3_my_q[2], s3_my_q[3]));
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: output register. Sizes are the extents, clipped to 31 bits.
  // --------------------------------------------------------------------------
  box_t s5_box_q, s5_box_d;

  always_comb begin
    s5_box_d.box_left   = s4_lo_x_q;
    s5_box_d.box_top    = s4_lo_y_q;
    s5_box_d.box_width  = span(s4_hi_x_q, s4_lo_x_q);
    s5_box_d.box_height = span(s4_hi_y_q, s4_lo_y_q);
  end

  always_ff @(posedge clk_i) begin
    if (s5_en) begin
      s5_box_q <= s5_box_d;
    end
  end

  assign out_data_o = s5_box_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // The extent registers never hold a reversed range.
  a_extent_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_valid_q |-> ((s4_lo_x_q <= s4_hi_x_q) && (s4_lo_y_q <= s4_hi_y_q)))
    else $error("bounding extent has least above greatest");

  // The input side stalls only when every stage is full and the output waits.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s2_valid_q && s3_valid_q && s4_valid_q &&
                    s5_valid_q && out_stall_i))
    else $error("input stalled while the pipeline has a free slot");

  // With stage 4 empty and the output beat taken, no beat is invented.
  a_no_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s4_valid_q && (!s5_valid_q || !out_stall_i)) |=> !out_valid_o)
    else $error("output beat without a beat behind it");

  // While reset is held the translation is zero.
  a_offset_reset: assert property (@(posedge clk_i)
    !rst_ni |-> ((off_x_q == '0) && (off_y_q == '0)))
    else $error("offsets not cleared in reset");

endmodule

>>> tb/arb_box_sb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arb_box_sb_pkg: bounding box scoreboard for the affine rectangle block
// Keeps a private copy of the matrix registers, works out the enclosing box
// of every accepted rectangle and compares output beats against them in order.
// ----------------------------------------------------------------------------
package arb_box_sb_pkg;
  import arb_pkg::*;

  class box_scoreboard;
    coord_t coef_a;
    coord_t coef_b;
    coord_t coef_c;
    coord_t coef_d;
    coord_t offset_x;
    coord_t offset_y;
    box_t   expected_boxes[$];
    int     mismatches;

    function new();
      coef_a     = CoefOne;
      coef_b     = '0;
      coef_c     = '0;
      coef_d     = CoefOne;
      offset_x   = '0;
      offset_y   = '0;
      mismatches = 0;
    endfunction

    // Indexes past the last register are dropped, as in the block.
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] data);
      case (idx)
        RegCoefA:   coef_a   = data;
        RegCoefB:   coef_b   = data;
        RegCoefC:   coef_c   = data;
        RegCoefD:   coef_d   = data;
        RegOffsetX: offset_x = data;
        RegOffsetY: offset_y = data;
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > longint'(CoordMax)) return longint'(CoordMax);
      if (v < longint'(CoordMin)) return longint'(CoordMin);
      return v;
    endfunction

    // Arithmetic shift of the exact product floors toward negative infinity.
    function longint floor_prod(longint p, longint q);
      longint m;
      m = p * q;
      return m >>> FracBits;
    endfunction

    function longint map_axis(longint x, longint y, longint kx, longint ky,
                              longint off);
      return clamp32(floor_prod(x, kx) + floor_prod(y, ky) + off);
    endfunction

    function box_t bound_rect(rect_t r);
      longint x0, y0, x1, y1, mx, my;
      longint lo_x, hi_x, lo_y, hi_y, dw, dh;
      longint size_max;
      longint cx[4];
      longint cy[4];
      box_t   b;
      size_max = longint'(LenMax);
      x0 = longint'(r.rect_x);
      y0 = longint'(r.rect_y);
      x1 = clamp32(x0 + longint'(r.rect_w));
      y1 = clamp32(y0 + longint'(r.rect_h));
      cx[0] = x0; cy[0] = y0;
      cx[1] = x1; cy[1] = y0;
      cx[2] = x0; cy[2] = y1;
      cx[3] = x1; cy[3] = y1;
      lo_x = longint'(CoordMax); hi_x = longint'(CoordMin);
      lo_y = longint'(CoordMax); hi_y = longint'(CoordMin);
      for (int i = 0; i < 4; i++) begin
        mx = map_axis(cx[i], cy[i], coef_a, coef_c, offset_x);
        my = map_axis(cx[i], cy[i], coef_b, coef_d, offset_y);
        if (mx < lo_x) lo_x = mx;
        if (mx > hi_x) hi_x = mx;
        if (my < lo_y) lo_y = my;
        if (my > hi_y) hi_y = my;
      end
      dw = hi_x - lo_x;
      dh = hi_y - lo_y;
      if (dw > size_max) dw = size_max;
      if (dh > size_max) dh = size_max;
      b.box_left   = lo_x[CoordW-1:0];
      b.box_top    = lo_y[CoordW-1:0];
      b.box_width  = dw[LenW-1:0];
      b.box_height = dh[LenW-1:0];
      return b;
    endfunction

    function void note_rect(rect_t r);
      expected_boxes.push_back(bound_rect(r));
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_box(box_t got);
      box_t want;
      if (expected_boxes.size() == 0) begin
        $display("%0t: unexpected box beat, got left %0d top %0d width %0d height %0d",
                 $time, got.box_left, got.box_top, got.box_width, got.box_height);
        mismatches++;
        return;
      end
      want = expected_boxes.pop_front();
      compare_field("box_left", longint'(want.box_left), longint'(got.box_left));
      compare_field("box_top", longint'(want.box_top), longint'(got.box_top));
      compare_field("box_width", longint'(want.box_width), longint'(got.box_width));
      compare_field("box_height", longint'(want.box_height), longint'(got.box_height));
    endfunction

    function int pending();
      return expected_boxes.size();
    endfunction
  endclass

endpackage

>>> tb/affine_rect_bounds_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_rect_bounds_tb: self-checking bench for the affine rectangle bounds
// Streams rectangles through a set of matrices, from the reset identity over
// hand-picked extremes to random ones, with random gaps on both channels and
// one long output hold-off, and checks every box against a private predictor.
// ----------------------------------------------------------------------------
module affine_rect_bounds_tb;
  import arb_pkg::*;
  import arb_box_sb_pkg::*;

  // The limit leaves a wide margin over the length of the run.
  localparam int CycleLimit = 200000;
  // Long enough to fill the five-stage pipeline several times over.
  localparam int HoldOffCycles = 120;
  localparam int RandomPhases = 8;
  localparam int RectsPerPhase = 130;
  // Indexes past the register file; writes to them must have no effect.
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CoordW-1:0]  cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  rect_t              in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  box_t               out_data_o;

  box_scoreboard bounds_sb = new();
  // When set, neither side inserts gaps or stalls.
  bit calm;
  // Cycles still left in a forced output hold-off, counted by the receiver.
  int hold_left;
  int cycles;

  affine_rect_bounds dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: random stalls, none during a calm phase, and a solid stall
  // while a hold-off is pending so that the block backs up into its input.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 20);
      end
    end
  end

  // Output beats are sampled at the falling edge, where both the beat and the
  // stall that the next rising edge acts on are settled.
  initial begin
    forever begin
      @(negedge clk_i);
      if (rst_ni === 1'b1 && out_valid_o && !out_stall_i) begin
        bounds_sb.check_box(out_data_o);
      end
    end
  end

  function automatic coord_t pick_coord();
    int near;
    near = $urandom_range(1 << 25);
    case ($urandom_range(9))
      0: return CoordMax;
      1: return CoordMin;
      2: return '0;
      3, 4, 5, 6: return coord_t'(near - (1 << 24));
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic len_t pick_len();
    case ($urandom_range(9))
      0: return LenMax;
      1: return '0;
      2, 3, 4, 5, 6: return len_t'($urandom_range(1 << 24));
      default: return len_t'($urandom);
    endcase
  endfunction

  // Mostly modest scale factors so that boxes stay in range; the rest are
  // extremes and raw bit patterns.
  function automatic coord_t pick_coef();
    int near;
    near = $urandom_range(1 << 19);
    case ($urandom_range(9))
      0: return CoordMax;
      1: return CoordMin;
      2: return '0;
      3: return CoefOne;
      4: return -CoefOne;
      5, 6, 7: return coord_t'(near - (1 << 18));
      default: return coord_t'($urandom);
    endcase
  endfunction

  // One register write per clock; the caller lowers the write enable.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input coord_t data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    bounds_sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  // Only called with the pipeline empty. Two stray writes past the last
  // register go along each time and must leave the matrix untouched.
  task automatic load_matrix(input coord_t a, input coord_t b, input coord_t c,
                             input coord_t d, input coord_t ox, input coord_t oy);
    write_reg(RegCoefA, a);
    write_reg(RegSpareLo, coord_t'($urandom));
    write_reg(RegCoefB, b);
    write_reg(RegCoefC, c);
    write_reg(RegCoefD, d);
    write_reg(RegOffsetX, ox);
    write_reg(RegOffsetY, oy);
    write_reg(RegSpareHi, coord_t'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // Offers one rectangle and returns at the edge that accepts it. Valid
  // stays high between back-to-back beats, so it is assigned once per step.
  task automatic send_rect(input coord_t x, input coord_t y, input len_t w,
                           input len_t h);
    rect_t r;
    bit    taken;
    r.rect_x = x;
    r.rect_y = y;
    r.rect_w = w;
    r.rect_h = h;
    while (!calm && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    bounds_sb.note_rect(r);
  endtask

  // Every rectangle yields one box, so an empty scoreboard means idle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (bounds_sb.pending() != 0) @(posedge clk_i);
  endtask

  // Edge rectangles: empty, corners that overflow on either side, a corner
  // at each end of the range, and small fractional ones for the flooring.
  task automatic send_edge_rects();
    send_rect('0, '0, '0, '0);
    send_rect(CoordMax, CoordMax, LenMax, LenMax);
    send_rect(CoordMin, CoordMin, LenMax, LenMax);
    send_rect(CoordMin, CoordMax, '0, LenMax);
    send_rect(coord_t'(-1), coord_t'(-1), len_t'(1), len_t'(1));
    send_rect(coord_t'(3 * 65536), coord_t'(-163840), len_t'(98304), len_t'(16384));
    drain();
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    calm        = 1'b0;
    hold_left   = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: the reset identity, then matrices that push products,
    // sums and sizes into saturation, then negative and fractional factors
    // where flooring differs from truncation.
    send_edge_rects();
    load_matrix(CoordMax, CoordMin, CoordMin, CoordMax, CoordMax, CoordMin);
    send_edge_rects();
    load_matrix(CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin);
    send_edge_rects();
    load_matrix(coord_t'(-98304), coord_t'(32768), coord_t'(-16384),
                coord_t'(131071), coord_t'(-1), coord_t'(1));
    send_edge_rects();

    // Random part: a fresh matrix per phase. Phase 1 carries the long
    // output hold-off; phase 3 runs with no gaps on either side.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      load_matrix(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                  pick_coord(), pick_coord());
      calm = (ph == 3);
      for (int n = 0; n < RectsPerPhase; n++) begin
        if (ph == 1 && n == 20) hold_left = HoldOffCycles;
        send_rect(pick_coord(), pick_coord(), pick_len(), pick_len());
      end
      drain();
    end
    calm = 1'b0;

    // Idle on after the drain so that a stray extra beat would still be seen.
    repeat (20) @(posedge clk_i);
    if (bounds_sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
